FILE: hw/rtl/smx_pkg.sv
// Shared constants and codes for the stack machine executor.
package smx_pkg;

  // Sizes of the stack and the register file
  localparam int STACK_DEPTH = 1024;
  localparam int REG_COUNT   = 8;

  // Field and storage widths
  localparam int DATA_W = 32;
  localparam int OP_W   = 4;
  localparam int KIND_W = 2;
  localparam int ERR_W  = 3;
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int REG_W  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int STEP_W = $clog2(DATA_W);

  // Opcodes
  localparam logic [OP_W-1:0] OP_HALT       = 4'd0;
  localparam logic [OP_W-1:0] OP_PUSH       = 4'd1;
  localparam logic [OP_W-1:0] OP_POP        = 4'd2;
  localparam logic [OP_W-1:0] OP_ADD        = 4'd3;
  localparam logic [OP_W-1:0] OP_SUB        = 4'd4;
  localparam logic [OP_W-1:0] OP_MUL        = 4'd5;
  localparam logic [OP_W-1:0] OP_DIV        = 4'd6;
  localparam logic [OP_W-1:0] OP_AND        = 4'd7;
  localparam logic [OP_W-1:0] OP_OR         = 4'd8;
  localparam logic [OP_W-1:0] OP_XOR        = 4'd9;
  localparam logic [OP_W-1:0] OP_MOD        = 4'd10;
  localparam logic [OP_W-1:0] OP_STORE      = 4'd11;
  localparam logic [OP_W-1:0] OP_LOAD       = 4'd12;
  localparam logic [OP_W-1:0] OP_PRINT_INT  = 4'd13;
  localparam logic [OP_W-1:0] OP_PRINT_CHAR = 4'd14;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_INT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CHAR = 2'd1;
  localparam logic [KIND_W-1:0] KIND_HALT = 2'd2;
  localparam logic [KIND_W-1:0] KIND_ERR  = 2'd3;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE  = 3'd0;
  localparam logic [ERR_W-1:0] ERR_DIV0  = 3'd1;
  localparam logic [ERR_W-1:0] ERR_UNDER = 3'd2;
  localparam logic [ERR_W-1:0] ERR_OVER  = 3'd3;
  localparam logic [ERR_W-1:0] ERR_REG   = 3'd4;

endpackage

FILE: hw/rtl/stack_machine_executor.sv
// Stack machine executor: stack memory, register file, ALU and serial divider.
// Each instruction is accepted in S_IDLE, which latches it and reads the entry
// below top from the synchronous stack memory, and is executed in S_EXEC once
// the output register is free; a print, halt or error leaves its result there.
// No new instruction is taken until S_IDLE comes back. Div and mod pass through
// S_DIV, one quotient bit per cycle in the shift-subtract divider, then S_FIN.
// Reset: synchronous; empties the stack, zeroes the register file, clears halt.
module stack_machine_executor (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  instr_valid,
  output logic                                  instr_ready,
  input  logic [smx_pkg::OP_W-1:0]              opcode,
  input  logic signed [smx_pkg::DATA_W-1:0]     operand,
  output logic                                  result_valid,
  input  logic                                  result_ready,
  output logic [smx_pkg::KIND_W-1:0]            kind,
  output logic signed [smx_pkg::DATA_W-1:0]     value,
  output logic [smx_pkg::ERR_W-1:0]             error_code
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } state_t;

  state_t state, state_next;

  // Architectural state; the top of stack lives in a register, the rest in memory
  logic [smx_pkg::CNT_W-1:0]  count, count_next;
  logic [smx_pkg::DATA_W-1:0] tos, tos_next;
  logic                       halted, halted_next;
  logic [smx_pkg::DATA_W-1:0] regfile [smx_pkg::REG_COUNT];
  logic [smx_pkg::DATA_W-1:0] mem [smx_pkg::STACK_DEPTH];
  logic [smx_pkg::DATA_W-1:0] rd_data;

  // Latched instruction
  logic [smx_pkg::OP_W-1:0]   op_q;
  logic [smx_pkg::DATA_W-1:0] opnd_q;

  // Divider
  logic [smx_pkg::DATA_W-1:0] div_quo, div_rem, div_dvs;
  logic [smx_pkg::STEP_W-1:0] div_cnt;
  logic                       div_qneg, div_rneg, div_is_mod;
  logic                       div_start;
  logic [smx_pkg::DATA_W-1:0] rem_sh;
  logic [smx_pkg::DATA_W:0]   rem_diff;
  logic [smx_pkg::DATA_W-1:0] div_result;

  // Control and datapath helpers
  logic                       exec_go;
  logic                       emit;
  logic [smx_pkg::KIND_W-1:0] emit_kind;
  logic [smx_pkg::DATA_W-1:0] emit_value;
  logic [smx_pkg::ERR_W-1:0]  emit_err;
  logic                       mem_we;
  logic                       reg_we;
  logic [smx_pkg::CNT_W-1:0]  cnt_m1, cnt_m2;
  logic [smx_pkg::ADDR_W-1:0] rd_addr;
  logic                       stk_empty, stk_full, stk_lt2, bad_reg;
  logic [smx_pkg::REG_W-1:0]  reg_idx;
  logic [smx_pkg::DATA_W-1:0] alu_a, alu_b, alu_out;

  assign instr_ready = (state == S_IDLE);
  assign exec_go     = !result_valid || result_ready;

  assign cnt_m1    = count - smx_pkg::CNT_W'(1);
  assign cnt_m2    = count - smx_pkg::CNT_W'(2);
  assign rd_addr   = cnt_m2[smx_pkg::ADDR_W-1:0];
  assign stk_empty = (count == '0);
  assign stk_full  = (count >= smx_pkg::CNT_W'(smx_pkg::STACK_DEPTH));
  assign stk_lt2   = (count < smx_pkg::CNT_W'(2));
  assign bad_reg   = opnd_q[smx_pkg::DATA_W-1] ||
                     (opnd_q >= smx_pkg::DATA_W'(smx_pkg::REG_COUNT));
  assign reg_idx   = opnd_q[smx_pkg::REG_W-1:0];

  // ALU for the binary operations other than div and mod: a is below top, b is top
  assign alu_a = rd_data;
  assign alu_b = tos;
  always_comb begin
    case (op_q)
      smx_pkg::OP_ADD: alu_out = alu_a + alu_b;
      smx_pkg::OP_SUB: alu_out = alu_a - alu_b;
      smx_pkg::OP_MUL: alu_out = alu_a * alu_b;
      smx_pkg::OP_AND: alu_out = alu_a & alu_b;
      smx_pkg::OP_OR:  alu_out = alu_a | alu_b;
      smx_pkg::OP_XOR: alu_out = alu_a ^ alu_b;
      default:         alu_out = alu_a + alu_b;
    endcase
  end

  // Divider step and sign fix-up of the final result
  assign rem_sh     = {div_rem[smx_pkg::DATA_W-2:0], div_quo[smx_pkg::DATA_W-1]};
  assign rem_diff   = {1'b0, rem_sh} - {1'b0, div_dvs};
  assign div_result = div_is_mod ? (div_rneg ? (~div_rem + 1'b1) : div_rem)
                                 : (div_qneg ? (~div_quo + 1'b1) : div_quo);

  // Next-state logic of the sequencer
  always_comb begin
    state_next  = state;
    count_next  = count;
    tos_next    = tos;
    halted_next = halted;
    emit        = 1'b0;
    emit_kind   = smx_pkg::KIND_INT;
    emit_value  = '0;
    emit_err    = smx_pkg::ERR_NONE;
    mem_we      = 1'b0;
    reg_we      = 1'b0;
    div_start   = 1'b0;
    case (state)
      S_IDLE: begin
        if (instr_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec_go) begin
          state_next = S_IDLE;
          if (!halted) begin
            case (op_q)
              smx_pkg::OP_HALT: begin
                emit        = 1'b1;
                emit_kind   = smx_pkg::KIND_HALT;
                halted_next = 1'b1;
              end
              smx_pkg::OP_PUSH: begin
                if (stk_full) begin
                  emit = 1'b1; emit_kind = smx_pkg::KIND_ERR;
                  emit_err = smx_pkg::ERR_OVER; halted_next = 1'b1;
                end else begin
                  mem_we     = !stk_empty;
                  tos_next   = opnd_q;
                  count_next = count + smx_pkg::CNT_W'(1);
                end
              end
              smx_pkg::OP_LOAD: begin
                if (bad_reg) begin
                  emit = 1'b1; emit_kind = smx_pkg::KIND_ERR;
                  emit_err = smx_pkg::ERR_REG; halted_next = 1'b1;
                end else if (stk_full) begin
                  emit = 1'b1; emit_kind = smx_pkg::KIND_ERR;
                  emit_err = smx_pkg::ERR_OVER; halted_next = 1'b1;
                end else begin
                  mem_we     = !stk_empty;
                  tos_next   = regfile[reg_idx];
                  count_next = count + smx_pkg::CNT_W'(1);
                end
              end
              smx_pkg::OP_STORE: begin
                if (bad_reg) begin
                  emit = 1'b1; emit_kind = smx_pkg::KIND_ERR;
                  emit_err = smx_pkg::ERR_REG; halted_next = 1'b1;
                end else if (stk_empty) begin
                  emit = 1'b1; emit_kind = smx_pkg::KIND_ERR;
                  emit_err = smx_pkg::ERR_UNDER; halted_next = 1'b1;
                end else begin
                  reg_we     = 1'b1;
                  tos_next   = rd_data;
                  count_next = cnt_m1;
                end
              end
              smx_pkg::OP_POP: begin
                if (stk_empty) begin
                  emit = 1'b1; emit_kind = smx_pkg::KIND_ERR;
                  emit_err = smx_pkg::ERR_UNDER; halted_next = 1'b1;
                end else begin
                  tos_next   = rd_data;
                  count_next = cnt_m1;
                end
              end
              smx_pkg::OP_PRINT_INT, smx_pkg::OP_PRINT_CHAR: begin
                emit = 1'b1;
                if (stk_empty) begin
                  emit_kind = smx_pkg::KIND_ERR;
                  emit_err = smx_pkg::ERR_UNDER; halted_next = 1'b1;
                end else begin
                  emit_kind  = (op_q == smx_pkg::OP_PRINT_INT) ? smx_pkg::KIND_INT
                                                               : smx_pkg::KIND_CHAR;
                  emit_value = tos;
                  tos_next   = rd_data;
                  count_next = cnt_m1;
                end
              end
              smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_MUL,
              smx_pkg::OP_AND, smx_pkg::OP_OR, smx_pkg::OP_XOR: begin
                if (stk_lt2) begin
                  emit = 1'b1; emit_kind = smx_pkg::KIND_ERR;
                  emit_err = smx_pkg::ERR_UNDER; halted_next = 1'b1;
                end else begin
                  tos_next   = alu_out;
                  count_next = cnt_m1;
                end
              end
              smx_pkg::OP_DIV, smx_pkg::OP_MOD: begin
                if (stk_lt2) begin
                  emit = 1'b1; emit_kind = smx_pkg::KIND_ERR;
                  emit_err = smx_pkg::ERR_UNDER; halted_next = 1'b1;
                end else if (tos == '0) begin
                  emit = 1'b1; emit_kind = smx_pkg::KIND_ERR;
                  emit_err = smx_pkg::ERR_DIV0; halted_next = 1'b1;
                end else begin
                  div_start  = 1'b1;
                  state_next = S_DIV;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      S_DIV: begin
        if (div_cnt == smx_pkg::STEP_W'(smx_pkg::DATA_W - 1)) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        tos_next   = div_result;
        count_next = cnt_m1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      halted <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      halted <= halted_next;
    end
  end

  // Top of stack and latched instruction
  always_ff @(posedge clk) begin
    tos <= tos_next;
    if (instr_valid && instr_ready) begin
      op_q   <= opcode;
      opnd_q <= $unsigned(operand);
    end
  end

  // Register file, reset to zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < smx_pkg::REG_COUNT; i++) begin
        regfile[i] <= '0;
      end
    end else if (reg_we) begin
      regfile[reg_idx] <= tos;
    end
  end

  // Stack memory: old top written back on a push or load, entry below top read on accept
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_m1[smx_pkg::ADDR_W-1:0]] <= tos;
    end
    if (instr_valid && instr_ready) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Shift-subtract divider on magnitudes, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (div_start) begin
      div_quo    <= rd_data[smx_pkg::DATA_W-1] ? (~rd_data + 1'b1) : rd_data;
      div_dvs    <= tos[smx_pkg::DATA_W-1] ? (~tos + 1'b1) : tos;
      div_rem    <= '0;
      div_cnt    <= '0;
      div_qneg   <= rd_data[smx_pkg::DATA_W-1] ^ tos[smx_pkg::DATA_W-1];
      div_rneg   <= rd_data[smx_pkg::DATA_W-1];
      div_is_mod <= (op_q == smx_pkg::OP_MOD);
    end else if (state == S_DIV) begin
      if (!rem_diff[smx_pkg::DATA_W]) begin
        div_rem <= rem_diff[smx_pkg::DATA_W-1:0];
      end else begin
        div_rem <= rem_sh;
      end
      div_quo <= {div_quo[smx_pkg::DATA_W-2:0], ~rem_diff[smx_pkg::DATA_W]};
      div_cnt <= div_cnt + smx_pkg::STEP_W'(1);
    end
  end

  // Output register: holds one result until the consumer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      kind       <= emit_kind;
      value      <= $signed(emit_value);
      error_code <= emit_err;
    end
  end

`ifndef SYNTHESIS
  // Stack occupancy never passes its depth
  assert property (@(posedge clk) disable iff (rst)
    count <= smx_pkg::CNT_W'(smx_pkg::STACK_DEPTH))
    else $error("stack count beyond depth");

  // A halted machine leaves the stack untouched
  assert property (@(posedge clk) disable iff (rst)
    halted && state == S_EXEC |=> $stable(count))
    else $error("stack changed after halt");

  // A halting result sets the halt flag
  assert property (@(posedge clk) disable iff (rst)
    emit && (emit_kind == smx_pkg::KIND_HALT || emit_kind == smx_pkg::KIND_ERR) |=> halted)
    else $error("halt result without halt flag");

  // Only error results carry an error code
  assert property (@(posedge clk) disable iff (rst)
    result_valid && kind != smx_pkg::KIND_ERR |-> error_code == smx_pkg::ERR_NONE)
    else $error("error code on a non-error result");

  // The divider never runs with a zero divisor
  assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> div_dvs != '0)
    else $error("divider running with zero divisor");
`endif

endmodule

FILE: tb/stack_machine_executor_test.sv
// Self-checking testbench for the stack machine executor: directed script, random programs.
module stack_machine_executor_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Opcode 15 has no name in the package: it does nothing
  localparam logic [smx_pkg::OP_W-1:0] OP_NOP = 4'd15;

  localparam int RANDOM_ITEMS = 400;
  localparam int RX_HOLD      = 400;
  localparam int SETTLE       = 64;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int SCRIPT_LEN   = 31;

  // One printed or halting output of the machine
  typedef struct packed {
    logic [smx_pkg::KIND_W-1:0] kind;
    logic [smx_pkg::DATA_W-1:0] value;
    logic [smx_pkg::ERR_W-1:0]  err;
  } emission_t;

  // Directed instruction; em is only used where fixed is set
  typedef struct packed {
    logic [smx_pkg::OP_W-1:0]   op;
    logic [smx_pkg::DATA_W-1:0] opnd;
    logic                       fixed;
    emission_t                  em;
  } script_row_t;

  logic                              clk;
  logic                              rst;
  logic                              instr_valid;
  logic                              instr_ready;
  logic [smx_pkg::OP_W-1:0]          opcode;
  logic signed [smx_pkg::DATA_W-1:0] operand;
  logic                              result_valid;
  logic                              result_ready;
  logic [smx_pkg::KIND_W-1:0]        kind;
  logic signed [smx_pkg::DATA_W-1:0] value;
  logic [smx_pkg::ERR_W-1:0]         error_code;

  stack_machine_executor dut (
    .clk          (clk),
    .rst          (rst),
    .instr_valid  (instr_valid),
    .instr_ready  (instr_ready),
    .opcode       (opcode),
    .operand      (operand),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .kind         (kind),
    .value        (value),
    .error_code   (error_code)
  );

  // Shadow machine state
  logic [smx_pkg::DATA_W-1:0] shadow_stack [smx_pkg::STACK_DEPTH];
  logic [smx_pkg::DATA_W-1:0] shadow_regs [smx_pkg::REG_COUNT];
  int                         shadow_depth;
  bit                         shadow_halted;

  emission_t   awaited_output [$];
  int unsigned faults;
  int unsigned cycle_count;
  bit          steady;
  bit          rx_hold_req;

  // Directed script: reset state, operand extremes, wrap, truncation, every opcode but halt and pop
  script_row_t script [SCRIPT_LEN] = '{
    '{smx_pkg::OP_LOAD,       32'd0,         1'b0,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_PRINT_INT,  32'd0,         1'b1,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_PUSH,       32'h7FFF_FFFF, 1'b0,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_PUSH,       32'd1,         1'b0,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_ADD,        32'hFFFF_FFFF, 1'b0,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_PRINT_INT,  32'd0,         1'b1,
      '{smx_pkg::KIND_INT, 32'h8000_0000, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_PUSH,       32'h8000_0000, 1'b0,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_PUSH,       32'hFFFF_FFFF, 1'b0,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_DIV,        32'd0,         1'b0,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_PRINT_INT,  32'd0,         1'b1,
      '{smx_pkg::KIND_INT, 32'h8000_0000, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_PUSH,       32'h8000_0000, 1'b0,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_PUSH,       32'hFFFF_FFFF, 1'b0,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_MOD,        32'h8000_0000, 1'b0,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_PRINT_INT,  32'd0,         1'b1,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_PUSH,       32'hFFFF_FFF9, 1'b0,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_STORE,      32'd7,         1'b0,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_LOAD,       32'd7,         1'b0,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_PUSH,       32'd2,         1'b0,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_DIV,        32'd0,         1'b0,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_PUSH,       32'h5555_AAAA, 1'b0,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_XOR,        32'd0,         1'b0,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_PUSH,       32'h0F0F_0F0F, 1'b0,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_OR,         32'd0,         1'b0,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_PUSH,       32'hFFFF_00FF, 1'b0,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_AND,        32'd0,         1'b0,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_PUSH,       32'h0001_0003, 1'b0,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_MUL,        32'd0,         1'b0,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_LOAD,       32'd0,         1'b0,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_SUB,        32'd0,         1'b0,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}},
    '{OP_NOP,                 32'hA5A5_5A5A, 1'b0,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}},
    '{smx_pkg::OP_PRINT_CHAR, 32'd0,         1'b0,
      '{smx_pkg::KIND_INT, 32'h0, smx_pkg::ERR_NONE}}
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[stack_machine_executor] ERROR");
      $finish;
    end
  end

  // Executes one instruction on the shadow state; returns 1 if it emits
  function automatic bit execute_instr(input logic [smx_pkg::OP_W-1:0] op,
                                       input logic [smx_pkg::DATA_W-1:0] opnd,
                                       output emission_t em);
    logic [smx_pkg::DATA_W-1:0] a, b, r;
    logic [smx_pkg::ERR_W-1:0]  fault;
    longint                     sa, sb, q, idx;
    bit                         emits, bad_reg;
    em = '0;
    fault = smx_pkg::ERR_NONE;
    emits = 1'b0;
    if (shadow_halted) return 1'b0;
    idx = longint'($signed(opnd));
    bad_reg = (idx < 0) || (idx >= smx_pkg::REG_COUNT);
    case (op)
      smx_pkg::OP_HALT: begin
        em.kind = smx_pkg::KIND_HALT;
        emits = 1'b1;
      end
      smx_pkg::OP_PUSH, smx_pkg::OP_LOAD: begin
        if (op == smx_pkg::OP_LOAD && bad_reg) fault = smx_pkg::ERR_REG;
        else if (shadow_depth >= smx_pkg::STACK_DEPTH) fault = smx_pkg::ERR_OVER;
        else begin
          shadow_stack[shadow_depth] = (op == smx_pkg::OP_PUSH) ? opnd : shadow_regs[idx];
          shadow_depth++;
        end
      end
      smx_pkg::OP_POP, smx_pkg::OP_STORE, smx_pkg::OP_PRINT_INT,
      smx_pkg::OP_PRINT_CHAR: begin
        if (op == smx_pkg::OP_STORE && bad_reg) fault = smx_pkg::ERR_REG;
        else if (shadow_depth == 0) fault = smx_pkg::ERR_UNDER;
        else begin
          shadow_depth--;
          r = shadow_stack[shadow_depth];
          if (op == smx_pkg::OP_STORE) shadow_regs[idx] = r;
          else if (op != smx_pkg::OP_POP) begin
            em.kind = (op == smx_pkg::OP_PRINT_INT) ? smx_pkg::KIND_INT
                                                    : smx_pkg::KIND_CHAR;
            em.value = r;
            emits = 1'b1;
          end
        end
      end
      OP_NOP: ;
      default: begin
        // binary: b on top, a beneath, a op b replaces both
        if (shadow_depth < 2) fault = smx_pkg::ERR_UNDER;
        else begin
          b = shadow_stack[shadow_depth-1];
          a = shadow_stack[shadow_depth-2];
          sa = longint'($signed(a));
          sb = longint'($signed(b));
          if ((op == smx_pkg::OP_DIV || op == smx_pkg::OP_MOD) && b == '0)
            fault = smx_pkg::ERR_DIV0;
          else begin
            case (op)
              smx_pkg::OP_ADD:  r = a + b;
              smx_pkg::OP_SUB:  r = a - b;
              smx_pkg::OP_MUL:  r = a * b;
              smx_pkg::OP_AND:  r = a & b;
              smx_pkg::OP_OR:   r = a | b;
              smx_pkg::OP_XOR:  r = a ^ b;
              smx_pkg::OP_DIV: begin
                q = sa / sb;
                r = q[smx_pkg::DATA_W-1:0];
              end
              default: begin
                q = sa % sb;
                r = q[smx_pkg::DATA_W-1:0];
              end
            endcase
            shadow_depth--;
            shadow_stack[shadow_depth-1] = r;
          end
        end
      end
    endcase
    if (fault != smx_pkg::ERR_NONE) begin
      em.kind = smx_pkg::KIND_ERR;
      em.err = fault;
      emits = 1'b1;
    end
    if (emits && em.kind >= smx_pkg::KIND_HALT) shadow_halted = 1'b1;
    return emits;
  endfunction

  // Operand mix weighted towards the corners
  function automatic logic [smx_pkg::DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 32'd1;
      2:       return '1;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'h8000_0000;
      5, 6:    return $urandom_range(0, 40) - 20;
      default: return $urandom;
    endcase
  endfunction

  // Offers one transaction, waits for it to be taken and predicts its output
  task automatic issue(input logic [smx_pkg::OP_W-1:0] op,
                       input logic [smx_pkg::DATA_W-1:0] opnd,
                       input bit fixed = 1'b0, input emission_t fixed_em = '0);
    emission_t em;
    int unsigned gap;
    if (!steady && $urandom_range(99) < 17) begin
      gap = ($urandom_range(9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 3);
      instr_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    instr_valid <= 1'b1;
    opcode <= op;
    operand <= opnd;
    do @(posedge clk); while (!instr_ready);
    if (execute_instr(op, opnd, em)) awaited_output.push_back(fixed ? fixed_em : em);
  endtask

  // Sender pauses until everything predicted has come out
  task automatic let_results_settle();
    instr_valid <= 1'b0;
    do @(posedge clk); while (awaited_output.size() != 0);
  endtask

  // Well-formed random instruction that cannot halt the machine
  task automatic compose_instr(output logic [smx_pkg::OP_W-1:0] op,
                               output logic [smx_pkg::DATA_W-1:0] opnd);
    int unsigned roll;
    roll = $urandom_range(99);
    opnd = $urandom;
    if (roll < 4) op = OP_NOP;
    else if (shadow_depth < 2 || (shadow_depth < 24 && roll < 45)) begin
      if ($urandom_range(3) == 0) begin
        op = smx_pkg::OP_LOAD;
        opnd = $urandom_range(0, smx_pkg::REG_COUNT-1);
      end else begin
        op = smx_pkg::OP_PUSH;
        opnd = pick_word();
      end
    end else if (roll < 75) begin
      op = smx_pkg::OP_W'($urandom_range(smx_pkg::OP_ADD, smx_pkg::OP_MOD));
      if ((op == smx_pkg::OP_DIV || op == smx_pkg::OP_MOD) &&
          shadow_stack[shadow_depth-1] == '0) op = smx_pkg::OP_XOR;
    end else if (roll < 90) op = roll[0] ? smx_pkg::OP_PRINT_INT : smx_pkg::OP_PRINT_CHAR;
    else if (roll < 95) begin
      op = smx_pkg::OP_STORE;
      opnd = $urandom_range(0, smx_pkg::REG_COUNT-1);
    end else op = smx_pkg::OP_POP;
  endtask

  // Output monitor and checker
  always @(posedge clk) begin
    emission_t got, want;
    if (!rst && result_valid && result_ready) begin
      got = '{kind, value, error_code};
      if (awaited_output.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("unexpected output: kind %0d value %h err %0d", kind, value, error_code);
      end else begin
        want = awaited_output.pop_front();
        if (got.kind !== want.kind || got.value !== want.value || got.err !== want.err) begin
          faults++;
          if (faults <= 10)
            $display({"output mismatch: expected kind %0d value %h err %0d, ",
                      "got kind %0d value %h err %0d"},
                     want.kind, want.value, want.err, got.kind, got.value, got.err);
        end
      end
    end
  end

  // Receiver: random back-pressure, one long hold-off on request
  initial begin
    result_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        result_ready <= 1'b0;
        repeat (RX_HOLD) @(posedge clk);
      end else begin
        result_ready <= steady || ($urandom_range(99) >= 17);
      end
    end
  end

  // Stimulus
  initial begin
    logic [smx_pkg::OP_W-1:0]   op;
    logic [smx_pkg::DATA_W-1:0] opnd;
    int unsigned                done;
    faults = 0;
    steady = 1'b0;
    rx_hold_req = 1'b0;
    shadow_depth = 0;
    shadow_halted = 1'b0;
    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    rst <= 1'b1;
    instr_valid <= 1'b0;
    opcode <= smx_pkg::OP_HALT;
    operand <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed script
    foreach (script[i]) issue(script[i].op, script[i].opnd, script[i].fixed, script[i].em);
    let_results_settle();

    // random programs that keep the machine running
    done = 0;
    while (done < RANDOM_ITEMS) begin
      steady = (done >= 150 && done < 250);
      if (done == 60) rx_hold_req = 1'b1;
      if (done == 300) let_results_settle();
      compose_instr(op, opnd);
      issue(op, opnd);
      if (op != OP_NOP) done++;
    end
    steady = 1'b0;

    // end the program with one randomly chosen halt or error
    case ($urandom_range(0, 7))
      0: issue(smx_pkg::OP_HALT, $urandom);
      1, 2: begin
        issue(smx_pkg::OP_PUSH, pick_word());
        issue(smx_pkg::OP_PUSH, '0);
        issue($urandom_range(0, 1) ? smx_pkg::OP_DIV : smx_pkg::OP_MOD, $urandom);
      end
      3: begin
        // binary operation short of operands
        while (shadow_depth >= 2) issue(smx_pkg::OP_POP, $urandom);
        issue(smx_pkg::OP_W'($urandom_range(smx_pkg::OP_ADD, smx_pkg::OP_MOD)), $urandom);
      end
      4: begin
        // unary consumer on an empty stack
        while (shadow_depth > 0) issue(smx_pkg::OP_POP, $urandom);
        case ($urandom_range(0, 3))
          0:       issue(smx_pkg::OP_POP, $urandom);
          1:       issue(smx_pkg::OP_PRINT_INT, $urandom);
          2:       issue(smx_pkg::OP_PRINT_CHAR, $urandom);
          default: issue(smx_pkg::OP_STORE, $urandom_range(0, smx_pkg::REG_COUNT-1));
        endcase
      end
      5, 6: begin
        // fill the stack, then one more
        while (shadow_depth < smx_pkg::STACK_DEPTH) issue(smx_pkg::OP_PUSH, pick_word());
        if ($urandom_range(0, 1)) issue(smx_pkg::OP_PUSH, pick_word());
        else issue(smx_pkg::OP_LOAD, $urandom_range(0, smx_pkg::REG_COUNT-1));
      end
      default: begin
        // register index out of range, checked ahead of the stack
        case ($urandom_range(0, 5))
          0:       opnd = '1;
          1:       opnd = 32'h8000_0000;
          2:       opnd = smx_pkg::REG_COUNT;
          3:       opnd = 32'h7FFF_FFFF;
          4:       opnd = $urandom_range(smx_pkg::REG_COUNT, 1000);
          default: opnd = $urandom | 32'h8000_0000;
        endcase
        issue($urandom_range(0, 1) ? smx_pkg::OP_STORE : smx_pkg::OP_LOAD, opnd);
      end
    endcase

    // anything after a halt is dropped
    repeat (12) issue(smx_pkg::OP_W'($urandom_range(0, 15)), $urandom);

    let_results_settle();
    repeat (SETTLE) @(posedge clk);
    if (faults == 0) $display("[stack_machine_executor] OK");
    else $display("[stack_machine_executor] ERROR");
    $finish;
  end

endmodule
